// ===== rtl/bio_pkg.sv =====
// Shared types, widths and codes for the box overlap gate.
package bio_pkg;

	localparam int COORD_BITS = 12;
	localparam int MAX_REFS   = 16;
	localparam int CNT_W      = $clog2(MAX_REFS + 1);
	localparam int THR_W      = 9;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(77);

	// area of a box is the product of its x and y edge differences
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int AREA_W  = 2 * DIFF_W;
	localparam int SUM_W   = AREA_W + 1;
	localparam int UNI_W   = SUM_W + 1;
	localparam int INTER_W = 2 * COORD_BITS;
	localparam int LHS_W   = INTER_W + THR_W + 1;
	localparam int RHS_W   = SUM_W + THR_W + 1;

	// run counter load value that lets the chain settle after the head token is loaded
	localparam int RUN_LAST = MAX_REFS + 4;
	localparam int RUN_W    = $clog2(RUN_LAST + 1);

	localparam int S_TDATA_W = ((4 * COORD_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W = ((CNT_W + 2 + 7) / 8) * 8;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_TEST  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_AREA,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] yb;
		logic signed [COORD_BITS-1:0] xr;
		logic signed [COORD_BITS-1:0] yt;
		logic signed [COORD_BITS-1:0] xl;
	} box_t;

	// stored reference box with its precomputed area
	typedef struct packed {
		box_t                     box;
		logic signed [AREA_W-1:0] area;
	} ref_t;

	// candidate traveling down the chain; cnt_left counts live cells ahead
	typedef struct packed {
		box_t                     box;
		logic signed [AREA_W-1:0] area;
		logic [CNT_W-1:0]         cnt_left;
	} tok_t;

endpackage

// ===== rtl/bio_cell.sv =====
// One chain cell: holds a reference box and tests the passing candidate against it.
module bio_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bio_pkg::THR_W-1:0]   thr,
	input  logic                        shift_en,
	input  bio_pkg::ref_t               ref_in,
	output bio_pkg::ref_t               ref_out,
	input  bio_pkg::tok_t               tok_in,
	output bio_pkg::tok_t               tok_out,
	input  logic                        hit_in,
	output logic                        hit_out
);

	localparam int C = bio_pkg::COORD_BITS;

	bio_pkg::ref_t ref_q;
	bio_pkg::tok_t tok_q;

	logic signed [C-1:0] ix1, iy1, ix2, iy2;
	logic signed [C:0]   iw, ih;
	logic                empty, active;
	logic signed [bio_pkg::SUM_W-1:0] sum_ab;

	logic [C-1:0]                       iw_s1, ih_s1;
	logic                               empty_s1, active_s1;
	logic signed [bio_pkg::SUM_W-1:0]   sum_s1;

	logic [bio_pkg::INTER_W-1:0]        inter_s2;
	logic                               empty_s2, active_s2;
	logic signed [bio_pkg::SUM_W-1:0]   sum_s2;

	logic [bio_pkg::LHS_W-1:0]          lhs_s3;
	logic signed [bio_pkg::RHS_W-1:0]   rhs_s3;
	logic signed [bio_pkg::UNI_W-1:0]   uni_s3;
	logic                               empty_s3, active_s3;

	logic [bio_pkg::THR_W:0]            thr_plus;
	logic                               hit_s4, hit_q;
	logic                               uni_zero, uni_neg, ratio_ok;

	always_comb begin
		ix1 = (tok_in.box.xl > ref_q.box.xl) ? tok_in.box.xl : ref_q.box.xl;
		iy1 = (tok_in.box.yt > ref_q.box.yt) ? tok_in.box.yt : ref_q.box.yt;
		ix2 = (tok_in.box.xr < ref_q.box.xr) ? tok_in.box.xr : ref_q.box.xr;
		iy2 = (tok_in.box.yb < ref_q.box.yb) ? tok_in.box.yb : ref_q.box.yb;
		iw  = $signed({ix2[C-1], ix2}) - $signed({ix1[C-1], ix1});
		ih  = $signed({iy2[C-1], iy2}) - $signed({iy1[C-1], iy1});
		empty  = iw[C] || (iw == '0) || ih[C] || (ih == '0);
		active = (tok_in.cnt_left != '0);
		sum_ab = $signed({tok_in.area[bio_pkg::AREA_W-1], tok_in.area})
			+ $signed({ref_q.area[bio_pkg::AREA_W-1], ref_q.area});
		thr_plus = {1'b0, thr} + (bio_pkg::THR_W + 1)'(256);
	end

	// stored box shifts toward the tail on every add that finds room in the store
	always_ff @(posedge clk) begin
		if (shift_en) begin
			ref_q <= ref_in;
		end
	end

	always_ff @(posedge clk) begin
		tok_q.box  <= tok_in.box;
		tok_q.area <= tok_in.area;
		tok_q.cnt_left <= active ? (tok_in.cnt_left - 1'b1) : '0;

		iw_s1     <= iw[C-1:0];
		ih_s1     <= ih[C-1:0];
		empty_s1  <= empty;
		active_s1 <= active;
		sum_s1    <= sum_ab;

		inter_s2  <= {{C{1'b0}}, iw_s1} * {{C{1'b0}}, ih_s1};
		empty_s2  <= empty_s1;
		active_s2 <= active_s1;
		sum_s2    <= sum_s1;

		// inter*256 >= thr*(sum-inter)  <=>  inter*(256+thr) >= thr*sum
		lhs_s3    <= bio_pkg::LHS_W'(inter_s2) * bio_pkg::LHS_W'(thr_plus);
		rhs_s3    <= bio_pkg::RHS_W'($signed({1'b0, thr})) * bio_pkg::RHS_W'(sum_s2);
		uni_s3    <= bio_pkg::UNI_W'(sum_s2) - $signed(bio_pkg::UNI_W'(inter_s2));
		empty_s3  <= empty_s2;
		active_s3 <= active_s2;
	end

	always_comb begin
		uni_zero = (uni_s3 == '0);
		uni_neg  = uni_s3[bio_pkg::UNI_W-1];
		ratio_ok = $signed({{(bio_pkg::RHS_W - bio_pkg::LHS_W){1'b0}}, lhs_s3}) >= rhs_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s4 <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			hit_s4 <= active_s3 && (empty_s3 ? (thr == '0)
				: (uni_zero || (!uni_neg && ratio_ok)));
			hit_q  <= hit_in || hit_s4;
		end
	end

	assign ref_out = ref_q;
	assign tok_out = tok_q;
	assign hit_out = hit_q;

endmodule

// ===== rtl/box_iou_overlap_gate_unit.sv =====
// Top level: command decode, reference count, cell chain and result register.
//
//  channel   signals                                 carries
//  s         s_tvalid s_tready s_tdata s_tuser       box edges, opcode
//  m         m_tvalid m_tready m_tdata               hit, count, full flag
//  cfg       cfg_valid cfg_ready cfg_data            overlap threshold
//
// Clear, add and unused opcodes go from the input register through ST_AREA and ST_DONE to
// the result register. A test also waits in ST_RUN, for a span set by the candidate walking the
// cell chain one cell per cycle plus the four compare stages in each cell.
// arst_n clears the count, state, flags and sets the threshold to 77.
// A new input is taken while an earlier result still waits on m_tready.
module box_iou_overlap_gate_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bio_pkg::S_TDATA_W-1:0]   s_tdata,   // x_left, y_top, x_right, y_bottom
	input  logic [1:0]                      s_tuser,   // opcode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bio_pkg::M_TDATA_W-1:0]   m_tdata,   // overlap_hit, reference_count, store_full, pad
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bio_pkg::THR_W-1:0]       cfg_data   // overlap_threshold
);

	localparam int N = bio_pkg::MAX_REFS;
	localparam int C = bio_pkg::COORD_BITS;

	bio_pkg::state_t state_q, state_d;

	logic [1:0]                     op_q;
	bio_pkg::box_t                  box_q;
	logic [bio_pkg::CNT_W-1:0]      count_q;
	logic                           full_q;
	logic [bio_pkg::THR_W-1:0]      thr_q;
	logic [bio_pkg::RUN_W-1:0]      run_cnt_q;
	bio_pkg::tok_t                  head_q;
	logic                           m_tvalid_q;
	logic [bio_pkg::M_TDATA_W-1:0]  m_tdata_q;

	logic                           in_xfer, out_free, load_out, shift_en, has_room;
	logic signed [C:0]              dx, dy;
	logic signed [bio_pkg::AREA_W-1:0] area;
	bio_pkg::ref_t                  new_ref;

	bio_pkg::ref_t ref_chain [0:N];
	bio_pkg::tok_t tok_chain [0:N];
	logic          hit_chain [0:N];

	assign in_xfer   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign has_room  = (count_q < bio_pkg::CNT_W'(N));
	assign cfg_ready = 1'b1;

	always_comb begin
		dx   = $signed({box_q.xr[C-1], box_q.xr}) - $signed({box_q.xl[C-1], box_q.xl});
		dy   = $signed({box_q.yb[C-1], box_q.yb}) - $signed({box_q.yt[C-1], box_q.yt});
		area = bio_pkg::AREA_W'(dx) * bio_pkg::AREA_W'(dy);
		new_ref.box  = box_q;
		new_ref.area = area;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bio_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = bio_pkg::ST_AREA;
			end
			bio_pkg::ST_AREA: begin
				state_d = (op_q == bio_pkg::OP_TEST) ? bio_pkg::ST_RUN : bio_pkg::ST_DONE;
			end
			bio_pkg::ST_RUN: begin
				if (run_cnt_q == '0) state_d = bio_pkg::ST_DONE;
			end
			bio_pkg::ST_DONE: begin
				if (out_free) state_d = bio_pkg::ST_IDLE;
			end
			default: state_d = bio_pkg::ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		s_tready = 1'b0;
		shift_en = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			bio_pkg::ST_IDLE: s_tready = 1'b1;
			bio_pkg::ST_AREA: shift_en = (op_q == bio_pkg::OP_ADD) && has_room;
			bio_pkg::ST_RUN:  ;
			bio_pkg::ST_DONE: load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bio_pkg::ST_IDLE;
			count_q    <= '0;
			full_q     <= 1'b0;
			thr_q      <= bio_pkg::THR_RESET;
			run_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) thr_q <= cfg_data;
			if (state_q == bio_pkg::ST_AREA) begin
				full_q    <= (op_q == bio_pkg::OP_ADD) && !has_room;
				run_cnt_q <= bio_pkg::RUN_W'(bio_pkg::RUN_LAST);
				if (op_q == bio_pkg::OP_CLEAR) count_q <= '0;
				else if (shift_en) count_q <= count_q + 1'b1;
			end else if (state_q == bio_pkg::ST_RUN) begin
				run_cnt_q <= run_cnt_q - 1'b1;
			end
			if (load_out) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q  <= s_tuser;
			box_q <= s_tdata[4*C-1:0];
		end
		// candidate held at the chain head for the whole test
		if (state_q == bio_pkg::ST_AREA && op_q == bio_pkg::OP_TEST) begin
			head_q.box      <= box_q;
			head_q.area     <= area;
			head_q.cnt_left <= count_q;
		end
		if (load_out) begin
			m_tdata_q <= bio_pkg::M_TDATA_W'({full_q, count_q,
				(op_q == bio_pkg::OP_TEST) && hit_chain[N]});
		end
	end

	assign ref_chain[0] = new_ref;
	assign tok_chain[0] = head_q;
	assign hit_chain[0] = 1'b0;

	for (genvar k = 0; k < N; k++) begin : g_cell
		bio_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.thr      (thr_q),
			.shift_en (shift_en),
			.ref_in   (ref_chain[k]),
			.ref_out  (ref_chain[k+1]),
			.tok_in   (tok_chain[k]),
			.tok_out  (tok_chain[k+1]),
			.hit_in   (hit_chain[k]),
			.hit_out  (hit_chain[k+1])
		);
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bio_pkg::CNT_W'(N))
		else $error("reference count above capacity");

	a_add_counts: assert property (@(posedge clk) disable iff (!arst_n)
		shift_en |=> count_q == $past(count_q) + 1'b1)
		else $error("add did not advance the count");

	a_hit_only_test: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && op_q != bio_pkg::OP_TEST |=> !m_tdata_q[0])
		else $error("hit reported for a non-test command");

	a_full_only_add: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bio_pkg::ST_DONE && full_q
		|-> op_q == bio_pkg::OP_ADD && count_q == bio_pkg::CNT_W'(N))
		else $error("full flag without a dropped add");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bio_pkg::ST_RUN |-> !s_tready)
		else $error("input taken during a test");
`endif

endmodule
